// ===== rtl/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types and constants of the tab-separated cell tokenizer with hash.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

   localparam int LENGTH_BITS = 16;
   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   localparam logic [31:0] HASH_MULT_RESET = 32'd131;
   localparam logic [31:0] HASH_MASK       = 32'h7FFF_FFFF;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   localparam logic [1:0] END_TAB    = 2'd0;
   localparam logic [1:0] END_LINE   = 2'd1;
   localparam logic [1:0] END_STREAM = 2'd2;

   // result queue, depth must be a power of two
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [15:0] cell_length;
      logic [30:0] cell_hash;
      logic [1:0]  end_kind;
      logic        length_overflow;
      logic        run_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type slot0;
      result_type slot1;
   } push_type;

   function automatic logic [15:0] len_field(input logic [LENGTH_BITS-1:0] len);
      logic [31:0] ext;
      ext = 32'(len);
      return ext[15:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tct_ifs.sv =====
// ----------------------------------------------------------------------------
// tct channel interfaces
// Byte input, cell result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;
   modport source(output valid, byte_value, last_byte, input ready);
   modport sink(input valid, byte_value, last_byte, output ready);
endinterface

interface tct_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cell_length;
   logic [30:0] cell_hash;
   logic [1:0]  end_kind;
   logic        length_overflow;
   logic        run_last;
   modport source(output valid, cell_length, cell_hash, end_kind, length_overflow,
                  run_last, input ready);
   modport sink(input valid, cell_length, cell_hash, end_kind, length_overflow,
                run_last, output ready);
endinterface

interface tct_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tct_core.sv =====
// ----------------------------------------------------------------------------
// tct_core
// Input register, cell state and one multiply-add per byte; produces up to
// two results per byte for the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_core (
   input  logic                               clock,
   input  logic                               reset,
   tct_req_if.sink                            req_if,
   input  logic [31:0]                        hash_mult,
   input  logic [tct_pkg::RSP_CNT_BITS-1:0]   rsp_free,
   output tct_pkg::push_type                  push
);

   logic                             in_valid_ff, in_valid_in;
   logic [7:0]                       byte_ff;
   logic                             last_ff;

   logic [31:0]                      hash_ff, hash_in;
   logic [tct_pkg::LENGTH_BITS-1:0]  len_ff, len_in;
   logic                             ovf_ff, ovf_in;
   logic                             cr_pend_ff, cr_pend_in;

   logic                             take;
   logic                             fire;
   logic                             is_tab, is_lf, is_cr;
   logic                             swallow;
   logic                             byte_emit;
   logic [1:0]                       need;

   logic [31:0]                      base_hash;
   logic [tct_pkg::LENGTH_BITS-1:0]  base_len;
   logic                             base_ovf;
   logic [31:0]                      prod;
   logic [31:0]                      sx;
   logic [31:0]                      add_hash;
   logic [tct_pkg::LENGTH_BITS-1:0]  add_len;
   logic                             add_ovf;
   logic                             sat;

   tct_pkg::result_type              held_cell;
   tct_pkg::result_type              byte_cell;

   assign is_tab = byte_ff == tct_pkg::CH_TAB;
   assign is_lf  = byte_ff == tct_pkg::CH_LF;
   assign is_cr  = byte_ff == tct_pkg::CH_CR;

   // a pending cr means the cell state belongs to the held cell
   assign base_hash = cr_pend_ff ? 32'd0 : hash_ff;
   assign base_len  = cr_pend_ff ? '0 : len_ff;
   assign base_ovf  = cr_pend_ff ? 1'b0 : ovf_ff;

   assign prod     = base_hash * hash_mult;
   assign sx       = {{24{byte_ff[7]}}, byte_ff};
   assign add_hash = prod + sx;
   assign sat      = base_len == tct_pkg::LEN_MAX;
   assign add_len  = sat ? base_len : base_len + 1'b1;
   assign add_ovf  = base_ovf | sat;

   assign swallow = cr_pend_ff && is_lf;

   always_comb begin
      held_cell.cell_length     = tct_pkg::len_field(len_ff);
      held_cell.cell_hash       = hash_ff[30:0];
      held_cell.end_kind        = (swallow && last_ff) ? tct_pkg::END_STREAM
                                                       : tct_pkg::END_LINE;
      held_cell.length_overflow = ovf_ff;
      held_cell.run_last        = 1'b1;

      byte_emit                 = 1'b0;
      byte_cell.cell_length     = tct_pkg::len_field(base_len);
      byte_cell.cell_hash       = base_hash[30:0];
      byte_cell.end_kind        = tct_pkg::END_STREAM;
      byte_cell.length_overflow = base_ovf;
      byte_cell.run_last        = 1'b1;

      if (swallow) begin
         byte_emit = 1'b0;
      end else if (is_tab) begin
         byte_emit          = 1'b1;
         byte_cell.end_kind = last_ff ? tct_pkg::END_STREAM : tct_pkg::END_TAB;
      end else if (is_lf) begin
         byte_emit          = 1'b1;
         byte_cell.end_kind = last_ff ? tct_pkg::END_STREAM : tct_pkg::END_LINE;
      end else if (is_cr) begin
         byte_emit = last_ff;
      end else begin
         byte_emit                 = last_ff;
         byte_cell.cell_length     = tct_pkg::len_field(add_len);
         byte_cell.cell_hash       = add_hash[30:0];
         byte_cell.length_overflow = add_ovf;
      end

      need = {1'b0, cr_pend_ff} + {1'b0, byte_emit};
   end

   assign fire = in_valid_ff &&
                 (tct_pkg::RSP_CNT_BITS'(need) <= rsp_free);

   assign req_if.ready = !in_valid_ff || fire;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      push.count = fire ? need : 2'd0;
      push.slot1 = byte_cell;
      if (cr_pend_ff) begin
         push.slot0          = held_cell;
         push.slot0.run_last = !byte_emit;
      end else begin
         push.slot0 = byte_cell;
      end
   end

   always_comb begin
      in_valid_in = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      hash_in     = hash_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      cr_pend_in  = cr_pend_ff;
      if (fire) begin
         if (swallow || byte_emit) begin
            hash_in    = 32'd0;
            len_in     = '0;
            ovf_in     = 1'b0;
            cr_pend_in = 1'b0;
         end else if (is_cr) begin
            hash_in    = base_hash;
            len_in     = base_len;
            ovf_in     = base_ovf;
            cr_pend_in = 1'b1;
         end else begin
            hash_in    = add_hash;
            len_in     = add_len;
            ovf_in     = add_ovf;
            cr_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         hash_ff     <= 32'd0;
         len_ff      <= '0;
         ovf_ff      <= 1'b0;
         cr_pend_ff  <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         hash_ff     <= hash_in;
         len_ff      <= len_in;
         ovf_ff      <= ovf_in;
         cr_pend_ff  <= cr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_if.byte_value;
         last_ff <= req_if.last_byte;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tct_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// tct_rsp_fifo
// Small result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_rsp_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  tct_pkg::push_type                  push,
   output logic [tct_pkg::RSP_CNT_BITS-1:0]   rsp_free,
   tct_rsp_if.source                          rsp_if
);

   tct_pkg::result_type                mem_ff [tct_pkg::RSP_DEPTH];
   logic [tct_pkg::RSP_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tct_pkg::RSP_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tct_pkg::RSP_PTR_BITS-1:0]   wr_ptr_nxt;
   logic [tct_pkg::RSP_CNT_BITS-1:0]   count_ff, count_in;
   logic                               pop;
   tct_pkg::result_type                head;

   assign wr_ptr_nxt = wr_ptr_ff + 1'b1;
   assign head       = mem_ff[rd_ptr_ff];
   assign pop        = rsp_if.valid && rsp_if.ready;

   assign rsp_free = tct_pkg::RSP_CNT_BITS'(tct_pkg::RSP_DEPTH) - count_ff;

   assign rsp_if.valid           = count_ff != '0;
   assign rsp_if.cell_length     = head.cell_length;
   assign rsp_if.cell_hash       = head.cell_hash;
   assign rsp_if.end_kind        = head.end_kind;
   assign rsp_if.length_overflow = head.length_overflow;
   assign rsp_if.run_last        = head.run_last;

   assign count_in  = count_ff + tct_pkg::RSP_CNT_BITS'(push.count)
                      - tct_pkg::RSP_CNT_BITS'(pop);
   assign wr_ptr_in = wr_ptr_ff + tct_pkg::RSP_PTR_BITS'(push.count);
   assign rd_ptr_in = rd_ptr_ff + tct_pkg::RSP_PTR_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= push.slot1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tsv_cell_tokenizer_hash_top.sv =====
// ----------------------------------------------------------------------------
// tsv_cell_tokenizer_hash_top
// Splits a tab-separated byte stream into cells, giving length and hash.
// ----------------------------------------------------------------------------
// path: a byte taken into the input register pushes its results into the
// result queue once the queue has room; rsp_if is driven from the queue
// throughput: one byte per cycle while the result queue has room, set by the
// single 32x32 multiply-add loop on the running hash; one result per cycle out
// while rsp_if is ready, so a byte that closes two cells gives them one by one
// reset: synchronous, clears all cell state and sets the multiplier to 131
`default_nettype none

module tsv_cell_tokenizer_hash_top (
   input  logic        clock,
   input  logic        reset,
   tct_req_if.sink     req_if,
   tct_rsp_if.source   rsp_if,
   tct_csr_if.sink     csr_if
);

   logic [31:0]                        mult_ff, mult_in;
   logic [tct_pkg::RSP_CNT_BITS-1:0]   rsp_free;
   tct_pkg::push_type                  push;

   assign csr_if.ready = 1'b1;
   assign mult_in      = (csr_if.valid && csr_if.ready) ? csr_if.data : mult_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= tct_pkg::HASH_MULT_RESET;
      end else begin
         mult_ff <= mult_in;
      end
   end

   tct_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .hash_mult (mult_ff),
      .rsp_free  (rsp_free),
      .push      (push)
   );

   tct_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .rsp_free (rsp_free),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire
